@@ sv/msns_pkg.sv @@
// ----------------------------------------------------------------------------
// msns_pkg
// Shared types and constants of the max stability neighbor select unit.
// ----------------------------------------------------------------------------
package msns_pkg;

   localparam int MaxVehicles = 64;
   localparam int IdxW = $clog2(MaxVehicles);
   localparam int CntW = $clog2(MaxVehicles + 1);
   localparam int EntryW = 48;

   typedef enum logic [2:0] {
      ST_ADDED  = 3'd0,
      ST_FOUND  = 3'd1,
      ST_NONE   = 3'd2,
      ST_FULL   = 3'd3,
      ST_BADSRC = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRC_RD,
      S_SRC_LAT,
      S_CAND_RD,
      S_CAND_LAT,
      S_SQRT,
      S_DIV,
      S_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic append_wr;
      logic src_rd;
      logic src_latch;
      logic cand_rd;
      logic cand_latch;
      logic sqrt_step;
      logic div_start;
      logic div_step;
      logic compare;
      logic clear_best;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic div_done;
      logic found;
   } stat_type;

endpackage

@@ sv/msns_ram.sv @@
// ----------------------------------------------------------------------------
// msns_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module msns_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/msns_datapath.sv @@
// ----------------------------------------------------------------------------
// msns_datapath
// Entry table, bit-serial square root, restoring divider and best tracking.
// ----------------------------------------------------------------------------
module msns_datapath (
   input  logic                       clock,
   input  msns_pkg::cmd_type          cmd,
   input  logic [msns_pkg::IdxW-1:0]  addr,
   input  logic signed [15:0]         pos_x,
   input  logic signed [15:0]         pos_y,
   input  logic signed [15:0]         veh_speed,
   output msns_pkg::stat_type         stat,
   output logic [msns_pkg::IdxW-1:0]  best_entry,
   output logic [16:0]                best_dist,
   output logic [16:0]                best_stab
);

   logic [msns_pkg::EntryW-1:0] rd_data;
   logic signed [15:0] sx_ff, sy_ff, sv_ff;
   logic [16:0] dv_ff;
   logic [33:0] rem_ff, rem_in;
   logic [33:0] root_ff, root_in;
   logic [4:0]  sq_cnt_ff, sq_cnt_in;
   logic [20:0] quo_ff, quo_in;
   logic [18:0] drem_ff, drem_in;
   logic [18:0] den_ff;
   logic [4:0]  dv_cnt_ff, dv_cnt_in;
   logic [msns_pkg::IdxW-1:0] cidx_ff, best_ff;
   logic [16:0] bdist_ff, bstab_ff;
   logic found_ff;
   logic signed [16:0] ddx, ddy, ddv;
   logic [16:0] adx, ady, adv;
   logic [35:0] trial;
   logic [18:0] dshift;
   logic [19:0] dsub;

   msns_ram #(.Width(msns_pkg::EntryW), .Depth(msns_pkg::MaxVehicles)) u_table (
      .clock   (clock),
      .wr_en   (cmd.append_wr),
      .addr    (addr),
      .wr_data ({pos_x, pos_y, veh_speed}),
      .rd_data (rd_data)
   );

   always_comb begin
      ddx = 17'(sx_ff) - 17'($signed(rd_data[47:32]));
      ddy = 17'(sy_ff) - 17'($signed(rd_data[31:16]));
      ddv = 17'(sv_ff) - 17'($signed(rd_data[15:0]));
      adx = ddx[16] ? 17'(-ddx) : 17'(ddx);
      ady = ddy[16] ? 17'(-ddy) : 17'(ddy);
      adv = ddv[16] ? 17'(-ddv) : 17'(ddv);
   end

   // Digit-by-digit square root: remainder/root with bit position from sq_cnt.
   always_comb begin
      rem_in    = rem_ff;
      root_in   = root_ff;
      sq_cnt_in = sq_cnt_ff;
      trial = '0;
      if (cmd.cand_latch) begin
         rem_in    = 34'(adx) * 34'(adx) + 34'(ady) * 34'(ady);
         root_in   = '0;
         sq_cnt_in = 5'd17;
      end else if (cmd.sqrt_step) begin
         trial = {2'b0, root_ff} + (36'd1 << (2 * (sq_cnt_ff - 5'd1)));
         if ({2'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[33:0];
            root_in = (root_ff >> 1) + 34'(36'd1 << (2 * (sq_cnt_ff - 5'd1)));
         end else begin
            root_in = root_ff >> 1;
         end
         sq_cnt_in = sq_cnt_ff - 5'd1;
      end
   end

   assign dshift = {drem_ff[17:0], quo_ff[20]};
   assign dsub   = {1'b0, dshift} - {1'b0, den_ff};

   always_comb begin
      quo_in    = quo_ff;
      drem_in   = drem_ff;
      dv_cnt_in = dv_cnt_ff;
      if (cmd.div_start) begin
         quo_in    = 21'h100000;
         drem_in   = '0;
         dv_cnt_in = 5'd21;
      end else if (cmd.div_step) begin
         if (!dsub[19]) begin
            drem_in = dsub[18:0];
            quo_in  = {quo_ff[19:0], 1'b1};
         end else begin
            drem_in = dshift;
            quo_in  = {quo_ff[19:0], 1'b0};
         end
         dv_cnt_in = dv_cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      sq_cnt_ff <= sq_cnt_in;
      quo_ff    <= quo_in;
      drem_ff   <= drem_in;
      dv_cnt_ff <= dv_cnt_in;
      if (cmd.src_latch) begin
         sx_ff <= $signed(rd_data[47:32]);
         sy_ff <= $signed(rd_data[31:16]);
         sv_ff <= $signed(rd_data[15:0]);
      end
      if (cmd.cand_latch) begin
         dv_ff   <= adv;
         cidx_ff <= addr;
      end
      if (cmd.div_start) begin
         den_ff <= 19'd16 + 19'(dv_ff) + 19'(root_ff);
      end
      if (cmd.clear_best) begin
         found_ff <= 1'b0;
         best_ff  <= '0;
         bdist_ff <= '0;
         bstab_ff <= '0;
      end else if (cmd.compare && (quo_ff > 21'(bstab_ff))) begin
         found_ff <= 1'b1;
         best_ff  <= cidx_ff;
         bdist_ff <= root_ff[16:0];
         bstab_ff <= quo_ff[16:0];
      end
   end

   assign stat.sqrt_done = (sq_cnt_ff == 5'd0);
   assign stat.div_done  = (dv_cnt_ff == 5'd0);
   assign stat.found     = found_ff;
   assign best_entry     = best_ff;
   assign best_dist      = bdist_ff;
   assign best_stab      = bstab_ff;

endmodule

@@ sv/msns_ctrl.sv @@
// ----------------------------------------------------------------------------
// msns_ctrl
// Command sequencer: append, source fetch and candidate scan.
// ----------------------------------------------------------------------------
module msns_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       command,
   input  logic [msns_pkg::IdxW-1:0]  source_entry,
   input  msns_pkg::stat_type         stat,
   output msns_pkg::cmd_type          cmd,
   output logic [msns_pkg::IdxW-1:0]  addr,
   output logic                       busy,
   output logic                       done,
   output msns_pkg::status_type       status,
   output logic                       is_route,
   output logic [msns_pkg::IdxW-1:0]  src_idx
);

   msns_pkg::state_type state_ff, state_in;
   logic [msns_pkg::CntW-1:0] count_ff, count_in;
   logic [msns_pkg::CntW-1:0] scan_ff, scan_in;
   logic [msns_pkg::IdxW-1:0] src_ff, src_in;
   msns_pkg::status_type st_ff, st_in;
   logic route_ff, route_in;
   logic accept, full, bad_src, scan_end, skip;

   assign accept   = start && (state_ff == msns_pkg::S_IDLE);
   assign full     = (count_ff == msns_pkg::CntW'(msns_pkg::MaxVehicles));
   assign bad_src  = (msns_pkg::CntW'(source_entry) >= count_ff);
   assign scan_end = (scan_ff >= count_ff);
   assign skip     = (scan_ff[msns_pkg::IdxW-1:0] == src_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msns_pkg::S_IDLE: begin
            if (accept) begin
               if (!command || bad_src) begin
                  state_in = msns_pkg::S_DONE;
               end else begin
                  state_in = msns_pkg::S_SRC_RD;
               end
            end
         end
         msns_pkg::S_SRC_RD:  state_in = msns_pkg::S_SRC_LAT;
         msns_pkg::S_SRC_LAT: state_in = msns_pkg::S_CAND_RD;
         msns_pkg::S_CAND_RD: begin
            if (scan_end) begin
               state_in = msns_pkg::S_DONE;
            end else if (!skip) begin
               state_in = msns_pkg::S_CAND_LAT;
            end
         end
         msns_pkg::S_CAND_LAT: state_in = msns_pkg::S_SQRT;
         msns_pkg::S_SQRT: begin
            if (stat.sqrt_done) begin
               state_in = msns_pkg::S_DIV;
            end
         end
         msns_pkg::S_DIV: begin
            if (stat.div_done && !cmd.div_start) begin
               state_in = msns_pkg::S_CMP;
            end
         end
         msns_pkg::S_CMP:  state_in = msns_pkg::S_CAND_RD;
         msns_pkg::S_DONE: state_in = msns_pkg::S_IDLE;
         default:          state_in = msns_pkg::S_IDLE;
      endcase
   end

   // The divider is started on the first cycle of S_DIV, flagged by prev state.
   logic in_div_ff;

   always_comb begin
      cmd      = '0;
      addr     = scan_ff[msns_pkg::IdxW-1:0];
      count_in = count_ff;
      scan_in  = scan_ff;
      src_in   = src_ff;
      st_in    = st_ff;
      route_in = route_ff;
      case (state_ff)
         msns_pkg::S_IDLE: begin
            addr = count_ff[msns_pkg::IdxW-1:0];
            if (accept) begin
               route_in       = command;
               src_in         = source_entry;
               cmd.clear_best = 1'b1;
               scan_in        = '0;
               if (!command) begin
                  if (full) begin
                     st_in = msns_pkg::ST_FULL;
                  end else begin
                     cmd.append_wr = 1'b1;
                     count_in      = count_ff + 1'b1;
                     st_in         = msns_pkg::ST_ADDED;
                  end
               end else if (bad_src) begin
                  st_in = msns_pkg::ST_BADSRC;
               end
            end
         end
         msns_pkg::S_SRC_RD: begin
            addr       = src_ff;
            cmd.src_rd = 1'b1;
         end
         msns_pkg::S_SRC_LAT: begin
            cmd.src_latch = 1'b1;
         end
         msns_pkg::S_CAND_RD: begin
            cmd.cand_rd = 1'b1;
            if (scan_end) begin
               st_in = stat.found ? msns_pkg::ST_FOUND : msns_pkg::ST_NONE;
            end else if (skip) begin
               scan_in = scan_ff + 1'b1;
            end
         end
         msns_pkg::S_CAND_LAT: begin
            cmd.cand_latch = 1'b1;
         end
         msns_pkg::S_SQRT: begin
            cmd.sqrt_step = !stat.sqrt_done;
         end
         msns_pkg::S_DIV: begin
            cmd.div_start = !in_div_ff;
            cmd.div_step  = in_div_ff && !stat.div_done;
         end
         msns_pkg::S_CMP: begin
            cmd.compare = 1'b1;
            scan_in     = scan_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= msns_pkg::S_IDLE;
         count_ff  <= '0;
         in_div_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         in_div_ff <= (state_ff == msns_pkg::S_DIV);
      end
      scan_ff  <= scan_in;
      src_ff   <= src_in;
      st_ff    <= st_in;
      route_ff <= route_in;
   end

   assign busy     = (state_ff != msns_pkg::S_IDLE);
   assign done     = (state_ff == msns_pkg::S_DONE);
   assign status   = st_ff;
   assign is_route = route_ff;
   assign src_idx  = src_ff;

endmodule

@@ sv/max_stability_neighbor_select_unit.sv @@
// ----------------------------------------------------------------------------
// max_stability_neighbor_select_unit
// Vehicle table with a search for the most stable link from a source entry.
// An append or a rejected command gives its result in the cycle after
// the transfer. A route reads and latches the source, then runs the
// bit-serial square root and the radix-2 divider for each other stored
// entry. One command is worked at a time; busy stays high until the result
// strobe. Synchronous reset empties the table; the receiver cannot stall.
// ----------------------------------------------------------------------------
module max_stability_neighbor_select_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_veh_speed,
   input  logic [5:0]         req_source_entry,
   input  logic [5:0]         req_dest_label,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_best_entry,
   output logic [16:0]        rsp_path_distance,
   output logic [16:0]        rsp_link_stability,
   output logic [5:0]         rsp_source_echo,
   output logic [5:0]         rsp_dest_echo
);

   msns_pkg::cmd_type    cmd;
   msns_pkg::stat_type   stat;
   msns_pkg::status_type status;
   logic [msns_pkg::IdxW-1:0] addr, src_idx, best;
   logic [16:0] bdist, bstab;
   logic done, is_route, found_st;
   logic [5:0] dest_ff;

   msns_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .command      (req_command),
      .source_entry (req_source_entry),
      .stat         (stat),
      .cmd          (cmd),
      .addr         (addr),
      .busy         (busy),
      .done         (done),
      .status       (status),
      .is_route     (is_route),
      .src_idx      (src_idx)
   );

   msns_datapath u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .addr       (addr),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .veh_speed  (req_veh_speed),
      .stat       (stat),
      .best_entry (best),
      .best_dist  (bdist),
      .best_stab  (bstab)
   );

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         dest_ff <= req_dest_label;
      end
   end

   assign found_st           = (status == msns_pkg::ST_FOUND);
   assign rsp_valid          = done;
   assign rsp_status         = status;
   assign rsp_best_entry     = found_st ? best : '0;
   assign rsp_path_distance  = found_st ? bdist : '0;
   assign rsp_link_stability = found_st ? bstab : '0;
   assign rsp_source_echo    = is_route ? src_idx : '0;
   assign rsp_dest_echo      = is_route ? dest_ff : '0;

endmodule

@@ bench/max_stability_neighbor_select_unit_test.sv @@
// ----------------------------------------------------------------------------
// max_stability_neighbor_select_unit_test
// Self-checking bench for the vehicle table and most stable link search.
// Commands are driven over the start/busy handshake with random idle bursts.
// A scoreboard keeps its own copy of the table and predicts every response.
// Each strobed response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module max_stability_neighbor_select_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      msns_pkg::status_type status;
      logic [5:0]  best_entry;
      logic [16:0] path_distance;
      logic [16:0] link_stability;
      logic [5:0]  source_echo;
      logic [5:0]  dest_echo;
   } route_resp_type;

   class route_scoreboard;
      logic signed [15:0] tab_x [msns_pkg::MaxVehicles];
      logic signed [15:0] tab_y [msns_pkg::MaxVehicles];
      logic signed [15:0] tab_v [msns_pkg::MaxVehicles];
      int                 count;
      route_resp_type     expected_q[$];
      int                 errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned root;
         longint unsigned bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n = n - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      function longint unsigned abs_delta(logic signed [15:0] a, logic signed [15:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         return (d < 0) ? -d : d;
      endfunction

      function void note_command(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] v, logic [5:0] src, logic [5:0] dst);
         route_resp_type r;
         longint unsigned dx, dy, d, den, stab;
         r.status = msns_pkg::ST_ADDED;
         r.best_entry = '0;
         r.path_distance = '0;
         r.link_stability = '0;
         r.source_echo = '0;
         r.dest_echo = '0;
         if (cmd == 1'b0) begin
            if (count >= msns_pkg::MaxVehicles) begin
               r.status = msns_pkg::ST_FULL;
            end else begin
               tab_x[count] = x;
               tab_y[count] = y;
               tab_v[count] = v;
               count++;
            end
         end else begin
            r.source_echo = src;
            r.dest_echo = dst;
            if (int'(src) >= count) begin
               r.status = msns_pkg::ST_BADSRC;
            end else begin
               r.status = msns_pkg::ST_NONE;
               for (int i = 0; i < count; i++) begin
                  if (i != int'(src)) begin
                     dx = abs_delta(tab_x[src], tab_x[i]);
                     dy = abs_delta(tab_y[src], tab_y[i]);
                     d = int_sqrt(dx * dx + dy * dy);
                     den = 16 + abs_delta(tab_v[src], tab_v[i]) + d;
                     stab = (64'd1 << 20) / den;
                     if (stab > r.link_stability) begin
                        r.link_stability = 17'(stab);
                        r.path_distance = 17'(d);
                        r.best_entry = 6'(i);
                        r.status = msns_pkg::ST_FOUND;
                     end
                  end
               end
            end
         end
         expected_q.push_back(r);
      endfunction

      function void check_response(route_resp_type act);
         route_resp_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected response, status %0d", act.status);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (act.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, act.status);
            errors++;
         end
         if (act.best_entry !== e.best_entry) begin
            $error("best_entry: expected %0d, actual %0d", e.best_entry, act.best_entry);
            errors++;
         end
         if (act.path_distance !== e.path_distance) begin
            $error("path_distance: expected %0d, actual %0d",
                   e.path_distance, act.path_distance);
            errors++;
         end
         if (act.link_stability !== e.link_stability) begin
            $error("link_stability: expected %0d, actual %0d",
                   e.link_stability, act.link_stability);
            errors++;
         end
         if (act.source_echo !== e.source_echo) begin
            $error("source_echo: expected %0d, actual %0d", e.source_echo, act.source_echo);
            errors++;
         end
         if (act.dest_echo !== e.dest_echo) begin
            $error("dest_echo: expected %0d, actual %0d", e.dest_echo, act.dest_echo);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = 1'b0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic signed [15:0] req_veh_speed = '0;
   logic [5:0]         req_source_entry = '0;
   logic [5:0]         req_dest_label = '0;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [5:0]         rsp_best_entry;
   logic [16:0]        rsp_path_distance;
   logic [16:0]        rsp_link_stability;
   logic [5:0]         rsp_source_echo;
   logic [5:0]         rsp_dest_echo;

   route_scoreboard sb = new();

   max_stability_neighbor_select_unit DUT (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      route_resp_type act;
      if (!reset && rsp_valid) begin
         act.status = msns_pkg::status_type'(rsp_status);
         act.best_entry = rsp_best_entry;
         act.path_distance = rsp_path_distance;
         act.link_stability = rsp_link_stability;
         act.source_echo = rsp_source_echo;
         act.dest_echo = rsp_dest_echo;
         sb.check_response(act);
      end
   end

   task automatic send_command(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] v, logic [5:0] src, logic [5:0] dst);
      req_command <= cmd;
      req_pos_x <= x;
      req_pos_y <= y;
      req_veh_speed <= v;
      req_source_entry <= src;
      req_dest_label <= dst;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(cmd, x, y, v, src, dst);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_coord();
      if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
      return 16'(int'($urandom_range(0, 511)) - 256);
   endfunction

   task automatic send_append();
      send_command(1'b0, rand_coord(), rand_coord(), rand_coord(),
                   6'($urandom), 6'($urandom));
   endtask

   task automatic send_route();
      logic [5:0] src;
      if (sb.count > 0 && $urandom_range(0, 7) != 0) src = 6'($urandom_range(0, sb.count - 1));
      else src = 6'($urandom);
      send_command(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), src, 6'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Route on an empty table, then a lone source.
      send_command(1'b1, '0, '0, '0, 6'd0, 6'd63);
      send_command(1'b0, -16'sd32768, -16'sd32768, -16'sd32768, 6'd63, 6'd63);
      send_command(1'b1, '0, '0, '0, 6'd0, 6'd5);
      send_command(1'b1, '0, '0, '0, 6'd1, 6'd0);
      send_command(1'b0, 16'sd32767, 16'sd32767, 16'sd32767, 6'd0, 6'd0);
      send_command(1'b1, '0, '0, '0, 6'd0, 6'd42);
      // Equal links: the lower index must be kept.
      send_command(1'b0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0);
      send_command(1'b0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0);
      send_command(1'b0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0);
      send_command(1'b1, '0, '0, '0, 6'd2, 6'd1);
      send_command(1'b1, '0, '0, '0, 6'd4, 6'd2);
      send_command(1'b1, '0, '0, '0, 6'd63, 6'd63);
      for (int n = 0; n < 500; n++) begin
         if (n < 450 && $urandom_range(0, 3) == 0) idle_burst();
         if (sb.count < msns_pkg::MaxVehicles ? $urandom_range(0, 9) < 7
                                              : $urandom_range(0, 9) < 2)
            send_append();
         else
            send_route();
      end
      start <= 1'b0;
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
